// ===== hdl/hls2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hls2rgb_pkg
// Shared widths and hue constants of the HLS to RGB color converter.
// ----------------------------------------------------------------------------
package hls2rgb_pkg;

   // payload field width of every channel
   localparam int FIELD_W          = 13;
   // default number of fraction bits in a level (1.0 = 1 << bits)
   localparam int LEVEL_FRAC_DEF   = 12;

   // hue arithmetic, in sixteenths of a degree
   localparam int ANGLE_W          = 15;   // signed, holds hue +/- one third
   localparam int WEIGHT_W         = 10;   // ramp weight 0..960
   localparam int HUE_FULL         = 5760; // 360 degrees
   localparam int HUE_THIRD        = 1920; // 120 degrees
   localparam int HUE_RISE_END     = 960;
   localparam int HUE_HOLD_END     = 2880;
   localparam int HUE_FALL_END     = 3840;
   localparam int HUE_SEGMENT      = 960;  // 60 degrees, ramp divisor

   // 960 = 64 * 15: divide by a shift, then by fifteen through a reciprocal
   localparam int SEG_SHIFT        = 6;
   localparam int SEG_ODD          = 15;

   localparam int NUM_CHAN         = 3;    // red, green, blue

   typedef logic [FIELD_W-1:0]  field_type;
   typedef logic [WEIGHT_W-1:0] weight_type;

endpackage

// ===== hdl/hls_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hls_to_rgb_converter
// Fixed-point HLS to RGB color conversion, six register stages.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   req     | in        | req_valid/req_ready  | hue, lightness, saturation
//   rsp     | out       | rsp_valid/rsp_ready  | red, green, blue
//
// One transaction is accepted per clock while req_ready is high. It passes
// the stages in order (multiplier, level math, ramp product, reciprocal
// product, quotient fix-up, output add/clamp); rsp_valid rises once it
// reaches the last. Each stage has its own valid bit and loads when it is
// empty or its successor advances, so bubbles collapse and req_ready drops
// only once all six stages hold a transaction behind a stalled output.
// Synchronous reset clears only the valid bits.
//
module hls_to_rgb_converter
   import hls2rgb_pkg::*;
#(
   parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  field_type req_hue,
   input  field_type req_lightness,
   input  field_type req_saturation,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output field_type rsp_red,
   output field_type rsp_green,
   output field_type rsp_blue
);

   // ---------------------------------------------------------------------
   // Derived widths
   // ---------------------------------------------------------------------
   localparam int PROD_W  = 2 * FIELD_W - LEVEL_FRAC_BITS;          // (l*s)>>F
   localparam int LVL_W   = ((PROD_W > FIELD_W + 1) ? PROD_W : FIELD_W + 1) + 2;
   localparam int DMAG_W  = LVL_W + 1;                              // |m2 - m1|
   localparam int X_W     = DMAG_W + WEIGHT_W;                      // |d| * w
   localparam int Y_W     = X_W - SEG_SHIFT;                        // |d|*w / 64
   localparam int RCP_W   = Y_W - 3;                                // 2^Y_W / 15
   localparam int SUM_W   = LVL_W + 2;                              // m1 + ramp
   localparam int LEVEL_HALF = 1 << (LEVEL_FRAC_BITS - 1);

   localparam logic [RCP_W-1:0]           RECIP   = RCP_W'((64'd1 << Y_W) / SEG_ODD);
   localparam logic signed [SUM_W-1:0]    ONE_S   = SUM_W'(64'd1 << LEVEL_FRAC_BITS);
   localparam logic signed [ANGLE_W-1:0]  A_FULL  = ANGLE_W'(HUE_FULL);
   localparam logic signed [ANGLE_W-1:0]  A_THIRD = ANGLE_W'(HUE_THIRD);
   localparam logic signed [ANGLE_W-1:0]  A_RISE  = ANGLE_W'(HUE_RISE_END);
   localparam logic signed [ANGLE_W-1:0]  A_HOLD  = ANGLE_W'(HUE_HOLD_END);
   localparam logic signed [ANGLE_W-1:0]  A_FALL  = ANGLE_W'(HUE_FALL_END);
   localparam logic [Y_W:0]               ODD_Y   = (Y_W+1)'(SEG_ODD);

   // Ramp weight of one channel: the hue is wrapped once, then mapped to
   // 0..960 so that the ramp value is always m1 + (m2 - m1) * w / 960.
   // Holding m2 uses the full weight, holding m1 uses zero.
   function automatic weight_type hue_weight(input field_type h,
                                             input logic signed [ANGLE_W-1:0] off);
      logic signed [ANGLE_W-1:0] a;
      logic signed [ANGLE_W-1:0] fall;
      a = $signed({{(ANGLE_W-FIELD_W){1'b0}}, h}) + off;
      if (a > A_FULL) begin
         a = a - A_FULL;
      end
      if (a < 0) begin
         a = a + A_FULL;
      end
      fall = A_FALL - a;
      if (a < A_RISE) begin
         hue_weight = a[WEIGHT_W-1:0];
      end else if (a < A_HOLD) begin
         hue_weight = WEIGHT_W'(HUE_SEGMENT);
      end else if (a < A_FALL) begin
         hue_weight = fall[WEIGHT_W-1:0];
      end else begin
         hue_weight = '0;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stage control: a stage loads when empty or when its successor loads
   // ---------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic ld1, ld2, ld3, ld4, ld5, ld6;

   assign ld6 = !v6_ff || rsp_ready;
   assign ld5 = !v5_ff || ld6;
   assign ld4 = !v4_ff || ld5;
   assign ld3 = !v3_ff || ld4;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;

   assign req_ready = ld1;
   assign rsp_valid = v6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (ld1) v1_ff <= req_valid;
         if (ld2) v2_ff <= v1_ff;
         if (ld3) v3_ff <= v2_ff;
         if (ld4) v4_ff <= v3_ff;
         if (ld5) v5_ff <= v4_ff;
         if (ld6) v6_ff <= v5_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: lightness * saturation, truncated to level precision
   // ---------------------------------------------------------------------
   field_type                hue1_ff, lit1_ff, sat1_ff;
   logic [PROD_W-1:0]        prod1_ff, prod1_in;
   logic [2*FIELD_W-1:0]     full_prod;

   always_comb begin
      full_prod = req_lightness * req_saturation;
      prod1_in  = full_prod[2*FIELD_W-1:LEVEL_FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         hue1_ff  <= req_hue;
         lit1_ff  <= req_lightness;
         sat1_ff  <= req_saturation;
         prod1_ff <= prod1_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: levels m2 and m1, sign and size of their spread, weights
   // ---------------------------------------------------------------------
   logic signed [LVL_W-1:0]  m1_2_ff, m1_2_in;
   logic                     neg2_ff, neg2_in;
   logic [DMAG_W-1:0]        dmag2_ff, dmag2_in;
   weight_type               w2_ff [NUM_CHAN];
   weight_type               w2_in [NUM_CHAN];

   logic signed [LVL_W-1:0]  l_ext, s_ext, p_ext, m2_val;
   logic signed [DMAG_W-1:0] spread;

   always_comb begin
      l_ext = $signed({{(LVL_W-FIELD_W){1'b0}}, lit1_ff});
      s_ext = $signed({{(LVL_W-FIELD_W){1'b0}}, sat1_ff});
      p_ext = $signed({{(LVL_W-PROD_W){1'b0}}, prod1_ff});
      if (int'(lit1_ff) <= LEVEL_HALF) begin
         m2_val = l_ext + p_ext;
      end else begin
         m2_val = l_ext + s_ext - p_ext;
      end
      m1_2_in  = (l_ext <<< 1) - m2_val;
      // m2 - m1 = 2 * (m2 - l)
      spread   = (DMAG_W'(m2_val) - DMAG_W'(l_ext)) <<< 1;
      neg2_in  = spread[DMAG_W-1];
      dmag2_in = neg2_in ? DMAG_W'(-spread) : DMAG_W'(spread);
      w2_in[0] = hue_weight(hue1_ff, A_THIRD);
      w2_in[1] = hue_weight(hue1_ff, '0);
      w2_in[2] = hue_weight(hue1_ff, -A_THIRD);
   end

   always_ff @(posedge clock) begin
      if (ld2) begin
         m1_2_ff  <= m1_2_in;
         neg2_ff  <= neg2_in;
         dmag2_ff <= dmag2_in;
         w2_ff    <= w2_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: ramp numerator |m2 - m1| * w per channel
   // ---------------------------------------------------------------------
   logic signed [LVL_W-1:0]  m1_3_ff;
   logic                     neg3_ff;
   logic [X_W-1:0]           x3_ff [NUM_CHAN];
   logic [X_W-1:0]           x3_in [NUM_CHAN];

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         x3_in[c] = X_W'(dmag2_ff) * X_W'(w2_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (ld3) begin
         m1_3_ff <= m1_2_ff;
         neg3_ff <= neg2_ff;
         x3_ff   <= x3_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: drop the factor 64, estimate the quotient by fifteen
   // ---------------------------------------------------------------------
   logic signed [LVL_W-1:0]  m1_4_ff;
   logic                     neg4_ff;
   logic [Y_W-1:0]           y4_ff  [NUM_CHAN];
   logic [Y_W-1:0]           y4_in  [NUM_CHAN];
   logic [RCP_W-1:0]         qe4_ff [NUM_CHAN];
   logic [RCP_W-1:0]         qe4_in [NUM_CHAN];
   logic [Y_W+RCP_W-1:0]     rprod  [NUM_CHAN];

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         y4_in[c]  = x3_ff[c][X_W-1:SEG_SHIFT];
         rprod[c]  = (Y_W+RCP_W)'(y4_in[c]) * (Y_W+RCP_W)'(RECIP);
         qe4_in[c] = rprod[c][Y_W+RCP_W-1:Y_W];
      end
   end

   always_ff @(posedge clock) begin
      if (ld4) begin
         m1_4_ff <= m1_3_ff;
         neg4_ff <= neg3_ff;
         y4_ff   <= y4_in;
         qe4_ff  <= qe4_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: the estimate is low by at most one; fix it up
   // ---------------------------------------------------------------------
   logic signed [LVL_W-1:0]  m1_5_ff;
   logic                     neg5_ff;
   logic [RCP_W-1:0]         q5_ff [NUM_CHAN];
   logic [RCP_W-1:0]         q5_in [NUM_CHAN];
   logic [Y_W:0]             times15 [NUM_CHAN];
   logic [Y_W:0]             rem     [NUM_CHAN];

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         times15[c] = ((Y_W+1)'(qe4_ff[c]) << 4) - (Y_W+1)'(qe4_ff[c]);
         rem[c]     = (Y_W+1)'(y4_ff[c]) - times15[c];
         q5_in[c]   = (rem[c] >= ODD_Y) ? qe4_ff[c] + 1'b1 : qe4_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (ld5) begin
         m1_5_ff <= m1_4_ff;
         neg5_ff <= neg4_ff;
         q5_ff   <= q5_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 6: m1 plus the signed ramp step, clamp to [0, 1.0]
   // ---------------------------------------------------------------------
   field_type                out6_ff [NUM_CHAN];
   field_type                out6_in [NUM_CHAN];
   logic signed [SUM_W-1:0]  step    [NUM_CHAN];
   logic signed [SUM_W-1:0]  level   [NUM_CHAN];
   logic signed [SUM_W-1:0]  m1_ext;

   always_comb begin
      m1_ext = SUM_W'(m1_5_ff);
      for (int c = 0; c < NUM_CHAN; c++) begin
         step[c]  = $signed({1'b0, q5_ff[c][SUM_W-2:0]});
         // truncation toward zero: negate the magnitude quotient
         level[c] = neg5_ff ? m1_ext - step[c] : m1_ext + step[c];
         if (level[c] < 0) begin
            out6_in[c] = '0;
         end else if (level[c] > ONE_S) begin
            out6_in[c] = ONE_S[FIELD_W-1:0];
         end else begin
            out6_in[c] = level[c][FIELD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld6) begin
         out6_ff <= out6_in;
      end
   end

   assign rsp_red   = out6_ff[0];
   assign rsp_green = out6_ff[1];
   assign rsp_blue  = out6_ff[2];

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // Request side may only stall when every stage holds a transaction.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && v6_ff))
      else $error("request stalled with an empty stage");

   // An accepted request lands in the first stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff)
      else $error("accepted request lost at stage 1");

   // A finished item behind a stalled output is held, not dropped.
   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && v6_ff && !rsp_ready) |=> (v5_ff && v6_ff))
      else $error("item dropped behind stalled output");

endmodule
